// ===== rtl/core/cct_pkg.sv =====
// shared constants, types and codes for the cross-correlation tdoa block
// no dependencies
package cct_pkg;

  localparam int MAX_WINDOW    = 16384;
  localparam int MAX_HALF_LAGS = 127;
  localparam int SAMPLE_BITS   = 16;
  localparam int ADDR_BITS     = $clog2(MAX_WINDOW);
  localparam int WLEN_BITS     = 15;
  localparam int LAG_BITS      = 8;
  localparam int SUM_BITS      = 46;
  localparam int PROD_BITS     = 2 * SAMPLE_BITS;

  // register indexes
  localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [1:0] REG_MAX_LAG    = 2'd1;
  localparam logic [1:0] REG_GUARD_LAGS = 2'd2;

  // limit codes
  localparam logic [1:0] LIMIT_NONE = 2'd0;
  localparam logic [1:0] LIMIT_POS  = 2'd1;
  localparam logic [1:0] LIMIT_NEG  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_LAGSET,
    S_RUN,
    S_DRAIN,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic wr_sample;
    logic init_search;
    logic start_lag;
    logic issue;
    logic cmp_update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic window_done;
    logic empty_range;
    logic last_issue;
    logic pipe_empty;
    logic last_lag;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/cct_if.sv =====
// handshake channels for sample pairs and correlation results
// depends on cct_pkg
interface cct_in_if;
  import cct_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface cct_out_if;
  import cct_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [LAG_BITS-1:0] lag_samples;
  logic [1:0]                 limit_code;
  logic signed [SUM_BITS-1:0] peak_sum;
  modport source (output valid, lag_samples, limit_code, peak_sum, input ready);
  modport sink (input valid, lag_samples, limit_code, peak_sum, output ready);
endinterface

// ===== rtl/core/cct_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module cct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cct_ctrl.sv =====
// sequencer for window load, per-lag accumulation and peak search
// depends on cct_pkg
module cct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cct_pkg::status_t  st,
  output cct_pkg::cmd_t     cmd
);
  import cct_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid && st.window_done) state_next = S_INIT;
      S_INIT:   state_next = S_LAGSET;
      S_LAGSET: state_next = st.empty_range ? S_DRAIN : S_RUN;
      S_RUN:    if (st.last_issue) state_next = S_DRAIN;
      S_DRAIN:  if (st.pipe_empty) state_next = S_CMP;
      S_CMP:    state_next = st.last_lag ? S_DONE : S_LAGSET;
      S_DONE:   if (st.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.wr_sample = in_valid;
      end
      S_INIT:   cmd.init_search = 1'b1;
      S_LAGSET: cmd.start_lag   = 1'b1;
      S_RUN:    cmd.issue       = 1'b1;
      S_DRAIN:  ;
      S_CMP:    cmd.cmp_update  = 1'b1;
      S_DONE:   cmd.load_out    = st.out_free;
      default:  ;
    endcase
  end

endmodule

// ===== rtl/core/cct_dp.sv =====
// datapath: sample stores, lag/index counters, mac pipeline, peak and result regs
// depends on cct_pkg and cct_ram
module cct_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  cct_pkg::cmd_t                       cmd,
  output cct_pkg::status_t                    st,
  input  logic signed [cct_pkg::SAMPLE_BITS-1:0] left_sample,
  input  logic signed [cct_pkg::SAMPLE_BITS-1:0] right_sample,
  input  logic [cct_pkg::WLEN_BITS-1:0]       window_len,
  input  logic [6:0]                          max_lag,
  input  logic [2:0]                          guard_lags,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cct_pkg::LAG_BITS-1:0] lag_samples,
  output logic [1:0]                          limit_code,
  output logic signed [cct_pkg::SUM_BITS-1:0] peak_sum
);
  import cct_pkg::*;

  logic [WLEN_BITS-1:0]          fill_count;
  logic [WLEN_BITS-1:0]          n_eff;
  logic [LAG_BITS-1:0]           h_eff;
  logic [LAG_BITS:0]             h_sum;
  logic signed [LAG_BITS:0]      lag;
  logic [WLEN_BITS-1:0]          j;
  logic signed [WLEN_BITS+1:0]   j0;
  logic signed [WLEN_BITS+1:0]   j1;
  logic signed [WLEN_BITS+1:0]   laddr;
  logic [SAMPLE_BITS-1:0]        lq, rq;
  logic                          v1, v2;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [SUM_BITS-1:0]    acc;
  logic signed [SUM_BITS-1:0]    best_sum;
  logic signed [LAG_BITS:0]      best_lag;
  logic                          first;
  logic signed [LAG_BITS:0]      lim;

  // effective window length and search half-width
  always_comb begin
    if (window_len == '0) begin
      n_eff = WLEN_BITS'(1);
    end else if (window_len > WLEN_BITS'(MAX_WINDOW)) begin
      n_eff = WLEN_BITS'(MAX_WINDOW);
    end else begin
      n_eff = window_len;
    end
    h_sum = (LAG_BITS+1)'(max_lag) + (LAG_BITS+1)'(guard_lags);
    h_eff = (h_sum > (LAG_BITS+1)'(MAX_HALF_LAGS)) ? LAG_BITS'(MAX_HALF_LAGS)
                                                   : h_sum[LAG_BITS-1:0];
  end

  // index range for the current lag
  always_comb begin
    j0 = (lag < 0) ? (WLEN_BITS+2)'(-lag) : '0;
    j1 = $signed({2'b00, n_eff}) - ((lag > 0) ? (WLEN_BITS+2)'(lag) : '0);
    laddr = $signed({2'b00, j}) + (WLEN_BITS+2)'(lag);
  end

  assign lim = $signed({2'b00, max_lag});

  always_comb begin
    st.window_done = (({1'b0, fill_count} + 16'd1) >= {1'b0, n_eff});
    st.empty_range = (j1 <= j0);
    st.last_issue  = ($signed({2'b00, j}) + 17'sd1) >= j1;
    st.pipe_empty  = !cmd.issue && !v1 && !v2;
    st.last_lag    = (lag == $signed({1'b0, h_eff}));
    st.out_free    = !out_valid || out_ready;
  end

  // sample stores
  cct_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_left (
    .clk(clk), .we(cmd.wr_sample), .waddr(fill_count[ADDR_BITS-1:0]),
    .wdata(left_sample), .raddr(laddr[ADDR_BITS-1:0]), .rdata(lq)
  );
  cct_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_right (
    .clk(clk), .we(cmd.wr_sample), .waddr(fill_count[ADDR_BITS-1:0]),
    .wdata(right_sample), .raddr(j[ADDR_BITS-1:0]), .rdata(rq)
  );

  // fill counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.wr_sample) begin
      fill_count <= st.window_done ? '0 : fill_count + WLEN_BITS'(1);
    end
  end

  // lag and index counters
  always_ff @(posedge clk) begin
    if (cmd.init_search) begin
      lag <= -$signed({1'b0, h_eff});
    end else if (cmd.cmp_update) begin
      lag <= lag + 9'sd1;
    end
    if (cmd.start_lag) begin
      j <= j0[WLEN_BITS-1:0];
    end else if (cmd.issue) begin
      j <= j + WLEN_BITS'(1);
    end
  end

  // multiply-accumulate pipeline: read, multiply, add
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
    prod <= $signed(lq) * $signed(rq);
    if (cmd.start_lag) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + SUM_BITS'(prod);
    end
  end

  // running peak, first lag wins on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      first    <= 1'b1;
      best_sum <= '0;
      best_lag <= '0;
    end else if (cmd.init_search) begin
      first <= 1'b1;
    end else if (cmd.cmp_update) begin
      if (first || acc > best_sum) begin
        best_sum <= acc;
        best_lag <= lag;
      end
      first <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      lag_samples <= best_lag[LAG_BITS-1:0];
      peak_sum    <= best_sum;
      if (best_lag == lim) begin
        limit_code <= LIMIT_POS;
      end else if (-best_lag == lim) begin
        limit_code <= LIMIT_NEG;
      end else begin
        limit_code <= LIMIT_NONE;
      end
    end
  end

endmodule

// ===== rtl/core/cross_correlation_tdoa.sv =====
// top level: apb register file, controller and datapath of the tdoa correlator
// depends on cct_pkg, cct_if, cct_ram, cct_ctrl, cct_dp
//
// channel   dir  payload                                   transaction when
// in_ch     in   left_sample, right_sample (s16 each)      valid && ready
// out_ch    out  lag_samples s8, limit_code 2, peak_sum s46 valid && ready
// apb       in   window_len, max_lag, guard_lags           psel&penable&pwrite
//
// sample pairs are taken one per cycle while the window fills; the last pair
// starts a search of (2H+1) lags through an init state. a lag with overlap
// n-|L| > 0 runs setup, reads (one per cycle, bounded by the single read
// port of each sample ram), drain and compare; an empty lag runs setup,
// drain and compare. input is not taken during the search; a finished result
// waits in the output register and the next window loads while it is pending.
// synchronous reset restores the config registers and empties the window.
module cross_correlation_tdoa (
  input  logic        clk,
  input  logic        rst,
  cct_in_if.sink      in_ch,
  cct_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cct_pkg::*;

  logic [WLEN_BITS-1:0] window_len;
  logic [6:0]           max_lag;
  logic [2:0]           guard_lags;
  cmd_t                 cmd;
  status_t              st;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WLEN_BITS'(9600);
      max_lag    <= 7'd64;
      guard_lags <= 3'd3;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WINDOW_LEN: window_len <= pwdata[WLEN_BITS-1:0];
        REG_MAX_LAG:    max_lag    <= pwdata[6:0];
        REG_GUARD_LAGS: guard_lags <= pwdata[2:0];
        default:        ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_LEN: prdata = {17'd0, window_len};
      REG_MAX_LAG:    prdata = {25'd0, max_lag};
      REG_GUARD_LAGS: prdata = {29'd0, guard_lags};
      default:        prdata = '0;
    endcase
  end

  cct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .st(st), .cmd(cmd)
  );

  cct_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .left_sample(in_ch.left_sample), .right_sample(in_ch.right_sample),
    .window_len(window_len), .max_lag(max_lag), .guard_lags(guard_lags),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .lag_samples(out_ch.lag_samples), .limit_code(out_ch.limit_code),
    .peak_sum(out_ch.peak_sum)
  );

`ifndef NO_ASSERTIONS
  // no sample taken while the mac pipeline is issuing reads
  a_no_load_in_search: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !cmd.issue)
    else $error("input accepted during search");

  // reads are issued only for lags with a nonempty overlap
  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !st.empty_range)
    else $error("read issued outside overlap");

  // a result is loaded only when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten");

  // limit code is always one of the defined codes
  a_limit_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ((out_ch.limit_code == LIMIT_NONE) ||
                      (out_ch.limit_code == LIMIT_POS) ||
                      (out_ch.limit_code == LIMIT_NEG)))
    else $error("bad limit code");
`endif

endmodule

// ===== dv/cross_correlation_tdoa_test.sv =====
// self-checking bench for the cross-correlation tdoa block: random windows, apb setup
// depends on cct_pkg, cct_if and the cross_correlation_tdoa rtl
module cross_correlation_tdoa_test;
  import cct_pkg::*;

  typedef struct {
    logic signed [LAG_BITS-1:0] lag;
    logic [1:0]                 code;
    logic signed [SUM_BITS-1:0] sum;
  } peak_t;

  // tracks window contents and the peak each completed window must produce
  class peak_scoreboard;
    int unsigned win_len, max_lag, guard;
    int signed   left_buf[MAX_WINDOW];
    int signed   right_buf[MAX_WINDOW];
    int unsigned fill;
    peak_t       pending[$];
    int          errors;
    int          checked;

    function void clear();
      win_len = 9600; max_lag = 64; guard = 3; fill = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // stores each pair; runs the correlation search once a window is full
    function void note_pair(logic signed [15:0] l, logic signed [15:0] r);
      int unsigned n, h;
      int signed lg, j;
      longint signed acc, best;
      int signed best_lg;
      peak_t p;
      n = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : win_len);
      if (fill < MAX_WINDOW) begin
        left_buf[fill] = int'(l); right_buf[fill] = int'(r); fill++;
      end
      if (fill < n) return;
      fill = 0;
      h = max_lag + guard;
      if (h > MAX_HALF_LAGS) h = MAX_HALF_LAGS;
      best = 0; best_lg = 0;
      for (lg = -int'(h); lg <= int'(h); lg++) begin
        acc = 0;
        for (j = (lg < 0 ? -lg : 0); j < (lg > 0 ? int'(n) - lg : int'(n)); j++)
          acc += longint'(left_buf[j + lg]) * longint'(right_buf[j]);
        if (lg == -int'(h) || acc > best) begin
          best = acc; best_lg = lg;
        end
      end
      p.lag = LAG_BITS'(best_lg);
      p.sum = SUM_BITS'(best);
      if (best_lg == int'(max_lag)) p.code = LIMIT_POS;
      else if (-best_lg == int'(max_lag)) p.code = LIMIT_NEG;
      else p.code = LIMIT_NONE;
      pending.insert(pending.size(), p);
    endfunction

    task check_peak(logic signed [7:0] lag, logic [1:0] code,
                    logic signed [45:0] sum);
      peak_t e;
      if (pending.size() == 0) begin
        report("result with nothing expected"); return;
      end
      e = pending[0];
      pending.delete(0);
      checked++;
      if (lag !== e.lag) report($sformatf("lag %0d, expected %0d", lag, e.lag));
      if (code !== e.code) report($sformatf("limit code %0d, expected %0d", code, e.code));
      if (sum !== e.sum) report($sformatf("peak sum %0d, expected %0d", sum, e.sum));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int unsigned cycles = 0;
  int unsigned hold_req = 0;
  bit quiet;
  bit done;
  peak_scoreboard sb;

  cct_in_if  in_ch ();
  cct_out_if out_ch ();

  cross_correlation_tdoa uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // sink: random stalls, long hold-offs on request
  initial begin
    int gap;
    int unsigned seen;
    int unsigned hold_left;
    seen = 0;
    hold_left = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_ch.ready = 0; hold_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 10);
        out_ch.ready = 0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1;
      end
    end
  end

  // result transactions go to the scoreboard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_peak(out_ch.lag_samples, out_ch.limit_code, out_ch.peak_sum);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] want;
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_WINDOW_LEN: begin
        sb.win_len = 32'(val[14:0]); want = {17'd0, val[14:0]};
      end
      REG_MAX_LAG: begin
        sb.max_lag = 32'(val[6:0]); want = {25'd0, val[6:0]};
      end
      REG_GUARD_LAGS: begin
        sb.guard = 32'(val[2:0]); want = {29'd0, val[2:0]};
      end
      default: want = '0;
    endcase
    @(negedge clk);
    if (prdata !== want)
      sb.report($sformatf("register %0d reads %0d, expected %0d", idx, prdata, want));
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1; in_ch.left_sample = l; in_ch.right_sample = r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_pair(l, r);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_pair();
    logic signed [15:0] l, r;
    case ($urandom_range(0, 3))
      0: begin l = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
               r = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000; end
      default: begin l = 16'($urandom); r = 16'($urandom); end
    endcase
    send_pair(l, r);
  endtask

  task automatic setup(int unsigned wl, int unsigned ml, int unsigned gl);
    drain();
    write_reg(REG_WINDOW_LEN, wl);
    write_reg(REG_MAX_LAG, ml);
    write_reg(REG_GUARD_LAGS, gl);
  endtask

  initial begin
    int unsigned k, phase;
    sb = new();
    sb.clear();
    in_ch.valid = 0; in_ch.left_sample = '0; in_ch.right_sample = '0;
    quiet = 0; done = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: tiny windows, extreme samples, lag limits and zero max lag
    setup(1, 0, 0);
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh8000, 16'sh8000);
    setup(0, 0, 7);
    send_pair(16'sh7fff, 16'sh7fff);
    send_pair(16'sh0000, 16'sh0001);
    setup(4, 1, 2);
    send_pair(0, 5); send_pair(5, 0); send_pair(0, 0); send_pair(0, 0);
    send_pair(0, 0); send_pair(0, 0); send_pair(0, 5); send_pair(5, 0);
    setup(3, 120, 7);
    for (k = 0; k < 6; k++) random_pair();
    // full hold-off while the sender keeps offering pairs
    setup(2, 3, 1);
    hold_req = hold_req + 1;
    for (k = 0; k < 10; k++) random_pair();

    // random phases of small windows and varied lag settings
    for (phase = 0; phase < 24; phase++) begin
      if (phase >= 20) quiet = 1;
      setup($urandom_range(1, 12), $urandom_range(0, 120), $urandom_range(0, 7));
      for (k = 0; k < 28; k++) random_pair();
    end
    // one moderately long window with pure noise
    setup(60, 5, 2);
    for (k = 0; k < 60; k++) random_pair();
    drain();
    $display("covered %0d windows across small and edge window lengths and lag ranges",
             sb.checked);
    done = 1;
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    if (!done && cycles > 4000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end
endmodule
